// File: src/cxlfr_pkg.sv
// Package for the CAN XL fragment reassembler: word types, status and kind codes,
// configuration indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package cxlfr_pkg;

	localparam int BUFFER_BYTES_DEF = 2048;

	localparam int LEN_W  = 12;
	localparam int CNT_W  = 16;
	localparam int PRIO_W = 11;
	localparam int ADDR_W = 11;
	localparam int CFG_W  = 12;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] CFG_TRANSFER_ID  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_MIN_FRAGMENT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_MAX_FRAGMENT = 2'd2;

	localparam logic [PRIO_W-1:0] RST_TRANSFER_ID  = 11'h242;
	localparam logic [LEN_W-1:0]  RST_MIN_FRAGMENT = 12'd1;
	localparam logic [LEN_W-1:0]  RST_MAX_FRAGMENT = 12'd2048;

	localparam logic [2:0] KIND_SINGLE      = 3'd0;
	localparam logic [2:0] KIND_FIRST       = 3'd1;
	localparam logic [2:0] KIND_CONSECUTIVE = 3'd2;
	localparam logic [2:0] KIND_LAST        = 3'd3;

	localparam logic [2:0] ST_NONE      = 3'd0;
	localparam logic [2:0] ST_STORED    = 3'd1;
	localparam logic [2:0] ST_COMPLETE  = 3'd2;
	localparam logic [2:0] ST_DUPLICATE = 3'd3;
	localparam logic [2:0] ST_BADSIZE   = 3'd4;
	localparam logic [2:0] ST_BADSEQ    = 3'd5;
	localparam logic [2:0] ST_OVERFLOW  = 3'd6;
	localparam logic [2:0] ST_IGNORED   = 3'd7;

	typedef struct packed {
		logic [2:0]        frame_kind;
		logic [CNT_W-1:0]  frame_count;
		logic [LEN_W-1:0]  fragment_len;
		logic [PRIO_W-1:0] frame_prio;
		logic [7:0]        frame_flags;
		logic [7:0]        frame_sdt;
		logic [31:0]       frame_af;
		logic [7:0]        payload_byte;
		logic              byte_valid;
		logic              frame_last;
	} in_word_t;

	typedef struct packed {
		logic              store_en;
		logic [ADDR_W-1:0] store_addr;
		logic [7:0]        store_byte;
		logic              frame_end;
		logic [2:0]        frame_status;
		logic [LEN_W-1:0]  packet_len;
		logic [PRIO_W-1:0] out_prio;
		logic [7:0]        out_flags;
		logic [7:0]        out_sdt;
		logic [31:0]       out_af;
	} out_word_t;

endpackage

// File: src/can_xl_fragment_reassembler_unit.sv
// An accepted input word passes through the input register and then the result register.
// One word per cycle while the result side is not stalled; a frame is judged combinationally on its first word.
// Result register holds while stalled; the input side stalls only when both registers are full.
// Reset (arst_n low, asynchronous): control and configuration registers return to reset values,
// frame state cleared, no counter known; the payload registers are not reset. Depends on cxlfr_pkg.
`timescale 1ns / 1ps

module can_xl_fragment_reassembler_unit #(
	parameter int BUFFER_BYTES = cxlfr_pkg::BUFFER_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  cxlfr_pkg::in_word_t           in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cxlfr_pkg::out_word_t          out_word,
	input  logic                          cfg_we,
	input  logic [cxlfr_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [cxlfr_pkg::CFG_W-1:0]   cfg_data
);

	localparam int LEN_W = cxlfr_pkg::LEN_W;
	localparam int OFS_W = $clog2(BUFFER_BYTES + 1);
	localparam int SUM_W = ((OFS_W > LEN_W) ? OFS_W : LEN_W) + 1;
	localparam logic [SUM_W-1:0] BUF_LIM = SUM_W'(BUFFER_BYTES);

	// configuration
	logic [cxlfr_pkg::PRIO_W-1:0] transfer_id_q;
	logic [LEN_W-1:0]             min_fragment_q;
	logic [LEN_W-1:0]             max_fragment_q;

	// frame and packet state
	logic                         count_known_q;
	logic [cxlfr_pkg::CNT_W-1:0]  last_count_q;
	logic [LEN_W-1:0]             fragment_size_q;
	logic [OFS_W-1:0]             write_offset_q;
	logic [OFS_W-1:0]             packet_length_q;
	logic [cxlfr_pkg::PRIO_W-1:0] held_prio_q;
	logic [7:0]                   held_flags_q;
	logic [7:0]                   held_sdt_q;
	logic [31:0]                  held_af_q;
	logic                         in_frame_q;
	logic [2:0]                   frame_action_q;
	logic [LEN_W-1:0]             byte_index_q;
	logic [OFS_W-1:0]             frame_base_q;
	logic [LEN_W-1:0]             frame_len_q;

	// pipeline
	logic                 valid_s1;
	cxlfr_pkg::in_word_t  word_s1;
	logic                 out_valid_q;
	cxlfr_pkg::out_word_t out_word_q;
	logic                 adv;

	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// judge of a frame's first word
	logic [2:0]                  j_act;
	logic                        j_known;
	logic [cxlfr_pkg::CNT_W-1:0] j_last;
	logic [LEN_W-1:0]            j_fs;
	logic [OFS_W-1:0]            j_wo;
	logic [OFS_W-1:0]            j_pl;
	logic                        j_hdr;
	logic [OFS_W-1:0]            j_base;
	logic [LEN_W-1:0]            j_len;
	logic [cxlfr_pkg::CNT_W-1:0] lc_eff;
	logic [SUM_W-1:0]            len_ext;
	logic [SUM_W-1:0]            wo_sum;
	logic [SUM_W-1:0]            pl_sum;

	always_comb begin
		j_act   = cxlfr_pkg::ST_IGNORED;
		j_known = count_known_q;
		j_last  = last_count_q;
		j_fs    = fragment_size_q;
		j_wo    = write_offset_q;
		j_pl    = packet_length_q;
		j_hdr   = 1'b0;
		j_base  = '0;
		j_len   = '0;
		lc_eff  = count_known_q ? last_count_q : word_s1.frame_count;
		len_ext = SUM_W'(word_s1.fragment_len);
		wo_sum  = SUM_W'(write_offset_q) + len_ext;
		pl_sum  = SUM_W'(packet_length_q) + len_ext;
		if (word_s1.frame_prio == transfer_id_q) begin
			j_known = 1'b1;
			j_last  = lc_eff;
			priority if (count_known_q && last_count_q == word_s1.frame_count) begin
				j_act = cxlfr_pkg::ST_DUPLICATE;
			end else if (word_s1.frame_kind == cxlfr_pkg::KIND_SINGLE) begin
				j_last = word_s1.frame_count;
				if (len_ext > BUF_LIM) begin
					j_act = cxlfr_pkg::ST_OVERFLOW;
				end else begin
					j_hdr = 1'b1;
					j_pl  = OFS_W'(word_s1.fragment_len);
					j_len = word_s1.fragment_len;
					j_act = cxlfr_pkg::ST_COMPLETE;
				end
			end else if (word_s1.frame_kind == cxlfr_pkg::KIND_FIRST) begin
				if (word_s1.fragment_len < min_fragment_q ||
				    word_s1.fragment_len > max_fragment_q) begin
					j_act = cxlfr_pkg::ST_BADSIZE;
				end else begin
					j_last = word_s1.frame_count;
					if (len_ext > BUF_LIM) begin
						j_act = cxlfr_pkg::ST_OVERFLOW;
					end else begin
						j_hdr = 1'b1;
						j_pl  = OFS_W'(word_s1.fragment_len);
						j_wo  = OFS_W'(word_s1.fragment_len);
						j_fs  = word_s1.fragment_len;
						j_len = word_s1.fragment_len;
						j_act = cxlfr_pkg::ST_STORED;
					end
				end
			end else if (word_s1.frame_kind == cxlfr_pkg::KIND_CONSECUTIVE ||
			             word_s1.frame_kind == cxlfr_pkg::KIND_LAST) begin
				if (lc_eff + 16'd1 != word_s1.frame_count) begin
					j_act = cxlfr_pkg::ST_BADSEQ;
				end else begin
					j_last = word_s1.frame_count;
					if ((word_s1.frame_kind == cxlfr_pkg::KIND_CONSECUTIVE) ?
					    (word_s1.fragment_len != fragment_size_q) :
					    (word_s1.fragment_len > fragment_size_q)) begin
						j_act = cxlfr_pkg::ST_BADSIZE;
					end else if (wo_sum > BUF_LIM || pl_sum > BUF_LIM) begin
						j_act = cxlfr_pkg::ST_OVERFLOW;
					end else begin
						j_base = write_offset_q;
						j_len  = word_s1.fragment_len;
						j_wo   = OFS_W'(wo_sum);
						j_pl   = OFS_W'(pl_sum);
						j_act  = (word_s1.frame_kind == cxlfr_pkg::KIND_CONSECUTIVE) ?
						         cxlfr_pkg::ST_STORED : cxlfr_pkg::ST_COMPLETE;
					end
				end
			end else begin
				j_act = cxlfr_pkg::ST_IGNORED;
			end
		end
	end

	// per-word result
	logic [2:0]                   act;
	logic [OFS_W-1:0]             base;
	logic [LEN_W-1:0]             flen;
	logic [LEN_W-1:0]             idx;
	logic [LEN_W-1:0]             idx_nxt;
	logic [LEN_W-1:0]             pl_now;
	logic [cxlfr_pkg::PRIO_W-1:0] prio_now;
	logic [7:0]                   flags_now;
	logic [7:0]                   sdt_now;
	logic [31:0]                  af_now;
	logic [SUM_W-1:0]             base_ext;
	logic [SUM_W-1:0]             pl_ext;
	logic                         storing;
	cxlfr_pkg::out_word_t         res;

	always_comb begin
		act      = in_frame_q ? frame_action_q : j_act;
		base     = in_frame_q ? frame_base_q : j_base;
		flen     = in_frame_q ? frame_len_q : j_len;
		idx      = in_frame_q ? byte_index_q : '0;
		idx_nxt  = (word_s1.byte_valid && idx != '1) ? idx + 1'b1 : idx;
		pl_ext   = SUM_W'(in_frame_q ? packet_length_q : j_pl);
		pl_now   = pl_ext[LEN_W-1:0];
		prio_now = (!in_frame_q && j_hdr) ? word_s1.frame_prio : held_prio_q;
		flags_now = (!in_frame_q && j_hdr) ? word_s1.frame_flags : held_flags_q;
		sdt_now  = (!in_frame_q && j_hdr) ? word_s1.frame_sdt : held_sdt_q;
		af_now   = (!in_frame_q && j_hdr) ? word_s1.frame_af : held_af_q;
		base_ext = SUM_W'(base) + SUM_W'(idx);
		storing  = (act == cxlfr_pkg::ST_STORED || act == cxlfr_pkg::ST_COMPLETE);
		res      = '0;
		if (word_s1.byte_valid && storing && idx < flen) begin
			res.store_en   = 1'b1;
			res.store_addr = base_ext[cxlfr_pkg::ADDR_W-1:0];
			res.store_byte = word_s1.payload_byte;
		end
		if (word_s1.frame_last) begin
			res.frame_end    = 1'b1;
			res.frame_status = act;
			if (act == cxlfr_pkg::ST_COMPLETE) begin
				res.packet_len = pl_now;
				res.out_prio   = prio_now;
				res.out_flags  = flags_now;
				res.out_sdt    = sdt_now;
				res.out_af     = af_now;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!in_stall) begin
			word_s1 <= in_word;
		end
		if (adv) begin
			out_word_q <= res;
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transfer_id_q   <= cxlfr_pkg::RST_TRANSFER_ID;
			min_fragment_q  <= cxlfr_pkg::RST_MIN_FRAGMENT;
			max_fragment_q  <= cxlfr_pkg::RST_MAX_FRAGMENT;
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			count_known_q   <= 1'b0;
			last_count_q    <= '0;
			fragment_size_q <= '0;
			write_offset_q  <= '0;
			packet_length_q <= '0;
			held_prio_q     <= '0;
			held_flags_q    <= '0;
			held_sdt_q      <= '0;
			held_af_q       <= '0;
			in_frame_q      <= 1'b0;
			frame_action_q  <= cxlfr_pkg::ST_NONE;
			byte_index_q    <= '0;
			frame_base_q    <= '0;
			frame_len_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cxlfr_pkg::CFG_TRANSFER_ID:  transfer_id_q  <= cfg_data[cxlfr_pkg::PRIO_W-1:0];
					cxlfr_pkg::CFG_MIN_FRAGMENT: min_fragment_q <= cfg_data;
					cxlfr_pkg::CFG_MAX_FRAGMENT: max_fragment_q <= cfg_data;
					default: ;
				endcase
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				if (!in_frame_q) begin
					count_known_q   <= j_known;
					last_count_q    <= j_last;
					fragment_size_q <= j_fs;
					write_offset_q  <= j_wo;
					packet_length_q <= j_pl;
					frame_base_q    <= j_base;
					frame_len_q     <= j_len;
					if (j_hdr) begin
						held_prio_q  <= word_s1.frame_prio;
						held_flags_q <= word_s1.frame_flags;
						held_sdt_q   <= word_s1.frame_sdt;
						held_af_q    <= word_s1.frame_af;
					end
				end
				if (word_s1.frame_last) begin
					in_frame_q     <= 1'b0;
					byte_index_q   <= '0;
					frame_action_q <= cxlfr_pkg::ST_NONE;
				end else begin
					in_frame_q     <= 1'b1;
					byte_index_q   <= idx_nxt;
					frame_action_q <= act;
				end
			end
		end
	end

endmodule

// File: src/cxlfr_checker.sv
// Port-level checker for can_xl_fragment_reassembler_unit, with its bind statement.
// Depends on cxlfr_pkg.
`timescale 1ns / 1ps

module cxlfr_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input cxlfr_pkg::out_word_t out_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	a_status_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.frame_end |-> out_word.frame_status == cxlfr_pkg::ST_NONE)
		else $error("status outside frame end");

	a_store_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.store_en |-> out_word.store_addr == '0 && out_word.store_byte == '0)
		else $error("store fields set without store");

	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.frame_status != cxlfr_pkg::ST_COMPLETE
		|-> out_word.packet_len == '0 && out_word.out_af == '0 && out_word.out_prio == '0)
		else $error("packet header set without complete status");

endmodule

bind can_xl_fragment_reassembler_unit cxlfr_checker u_cxlfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

// File: test/reassembly_checker.sv
// Result checker for the CAN XL fragment reassembler: predicts one result word per
// accepted input word and compares it field by field with what the unit sends.
// Depends on cxlfr_pkg.
`timescale 1ns / 1ps

module reassembly_checker
	import cxlfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  in_word_t            in_word,
	input  logic                out_valid,
	input  logic                out_stall,
	input  out_word_t           out_word,
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	output int                  errors,
	output int                  pending,
	output int                  compared,
	output int                  packets
);

	localparam int BUF_BYTES = BUFFER_BYTES_DEF;

	logic [PRIO_W-1:0] tid;
	int                min_len, max_len;

	logic              count_seen, mid_frame;
	logic [CNT_W-1:0]  prev_count;
	int                seg_size, wr_offset, asm_len;
	logic [PRIO_W-1:0] hdr_prio;
	logic [7:0]        hdr_flags, hdr_sdt;
	logic [31:0]       hdr_af;
	logic [2:0]        verdict;
	int                byte_idx, frame_base, frame_span;

	out_word_t expected_q[$];

	initial begin
		errors = 0;
		pending = 0;
		compared = 0;
		packets = 0;
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= 40)
			$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
	endtask

	function automatic logic [2:0] judge_frame(in_word_t w);
		int               len;
		logic [CNT_W-1:0] next_cnt;
		len = int'(w.fragment_len);
		frame_base = 0;
		frame_span = 0;
		if (w.frame_prio != tid)
			return ST_IGNORED;
		if (!count_seen) begin
			count_seen = 1'b1;
			prev_count = w.frame_count;
		end else if (prev_count == w.frame_count) begin
			return ST_DUPLICATE;
		end
		case (w.frame_kind)
			KIND_SINGLE: begin
				prev_count = w.frame_count;
				if (len > BUF_BYTES)
					return ST_OVERFLOW;
				hdr_prio = w.frame_prio;
				hdr_flags = w.frame_flags;
				hdr_sdt = w.frame_sdt;
				hdr_af = w.frame_af;
				asm_len = len;
				frame_span = len;
				return ST_COMPLETE;
			end
			KIND_FIRST: begin
				if (len < min_len || len > max_len)
					return ST_BADSIZE;
				prev_count = w.frame_count;
				if (len > BUF_BYTES)
					return ST_OVERFLOW;
				hdr_prio = w.frame_prio;
				hdr_flags = w.frame_flags;
				hdr_sdt = w.frame_sdt;
				hdr_af = w.frame_af;
				asm_len = len;
				wr_offset = len;
				seg_size = len;
				frame_span = len;
				return ST_STORED;
			end
			KIND_CONSECUTIVE, KIND_LAST: begin
				next_cnt = prev_count + 16'd1;
				if (next_cnt != w.frame_count)
					return ST_BADSEQ;
				prev_count = w.frame_count;
				if (w.frame_kind == KIND_CONSECUTIVE ? (len != seg_size) : (len > seg_size))
					return ST_BADSIZE;
				if (wr_offset + len > BUF_BYTES || asm_len + len > BUF_BYTES)
					return ST_OVERFLOW;
				frame_base = wr_offset;
				frame_span = len;
				wr_offset += len;
				asm_len += len;
				return (w.frame_kind == KIND_CONSECUTIVE) ? ST_STORED : ST_COMPLETE;
			end
			default: return ST_IGNORED;
		endcase
	endfunction

	function automatic out_word_t predict_word(in_word_t w);
		out_word_t r;
		r = '0;
		if (!mid_frame) begin
			verdict = judge_frame(w);
			byte_idx = 0;
			mid_frame = 1'b1;
		end
		if (w.byte_valid) begin
			if ((verdict == ST_STORED || verdict == ST_COMPLETE) && byte_idx < frame_span) begin
				r.store_en = 1'b1;
				r.store_addr = ADDR_W'(frame_base + byte_idx);
				r.store_byte = w.payload_byte;
			end
			if (byte_idx < 65535)
				byte_idx++;
		end
		if (w.frame_last) begin
			r.frame_end = 1'b1;
			r.frame_status = verdict;
			if (verdict == ST_COMPLETE) begin
				r.packet_len = LEN_W'(asm_len);
				r.out_prio = hdr_prio;
				r.out_flags = hdr_flags;
				r.out_sdt = hdr_sdt;
				r.out_af = hdr_af;
				packets++;
			end
			mid_frame = 1'b0;
			byte_idx = 0;
			verdict = ST_NONE;
		end
		return r;
	endfunction

	task automatic check_word(out_word_t got, out_word_t want);
		if (got.store_en !== want.store_en) report("store_en", got.store_en, want.store_en);
		if (got.store_addr !== want.store_addr)
			report("store_addr", got.store_addr, want.store_addr);
		if (got.store_byte !== want.store_byte)
			report("store_byte", got.store_byte, want.store_byte);
		if (got.frame_end !== want.frame_end) report("frame_end", got.frame_end, want.frame_end);
		if (got.frame_status !== want.frame_status)
			report("frame_status", got.frame_status, want.frame_status);
		if (got.packet_len !== want.packet_len)
			report("packet_len", got.packet_len, want.packet_len);
		if (got.out_prio !== want.out_prio) report("out_prio", got.out_prio, want.out_prio);
		if (got.out_flags !== want.out_flags) report("out_flags", got.out_flags, want.out_flags);
		if (got.out_sdt !== want.out_sdt) report("out_sdt", got.out_sdt, want.out_sdt);
		if (got.out_af !== want.out_af) report("out_af", got.out_af, want.out_af);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			tid = RST_TRANSFER_ID;
			min_len = int'(RST_MIN_FRAGMENT);
			max_len = int'(RST_MAX_FRAGMENT);
			count_seen = 1'b0;
			mid_frame = 1'b0;
			prev_count = '0;
			seg_size = 0;
			wr_offset = 0;
			asm_len = 0;
			hdr_prio = '0;
			hdr_flags = '0;
			hdr_sdt = '0;
			hdr_af = '0;
			verdict = ST_NONE;
			byte_idx = 0;
			frame_base = 0;
			frame_span = 0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0)
					report("word with nothing expected, status", out_word.frame_status, ST_NONE);
				else begin
					check_word(out_word, expected_q.pop_front());
					compared++;
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_word(in_word));
			if (cfg_we) begin
				case (cfg_index)
					CFG_TRANSFER_ID:  tid = cfg_data[PRIO_W-1:0];
					CFG_MIN_FRAGMENT: min_len = int'(cfg_data);
					CFG_MAX_FRAGMENT: max_len = int'(cfg_data);
					default: ;
				endcase
			end
			pending <= expected_q.size();
		end
	end

endmodule

// File: test/testbench.sv
// Top of the reassembler test: clock, reset, frame stimulus, configuration writes and
// receiver stalls, with reassembly_checker alongside the unit. Depends on cxlfr_pkg.
`timescale 1ns / 1ps

module testbench;
	import cxlfr_pkg::*;

	localparam logic [2:0] KIND_OTHER    = 3'd4;
	localparam logic [2:0] KIND_RESERVED = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                in_valid, in_stall;
	in_word_t            in_word;
	logic                out_valid, out_stall;
	out_word_t           out_word;
	logic                cfg_we;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	int errors, pending, compared, packets;
	int words_sent, settings;
	logic [PRIO_W-1:0] tid_cur;
	int                min_cur, max_cur;
	logic [CNT_W-1:0]  cnt_hint;
	logic              quiet;

	can_xl_fragment_reassembler_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	reassembly_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.compared  (compared),
		.packets   (packets)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_word(in_word_t w);
		int gap, r;
		if (quiet) gap = 0;
		else begin
			r = $urandom_range(0, 99);
			if (r < 65) gap = 0;
			else if (r < 90) gap = $urandom_range(1, 3);
			else if (r < 98) gap = $urandom_range(4, 12);
			else gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic send_frame(logic [2:0] kind, logic [CNT_W-1:0] cnt, logic [LEN_W-1:0] len,
			logic [PRIO_W-1:0] prio, int nbytes);
		in_word_t w;
		int       i;
		logic     tail;
		w.frame_kind = kind;
		w.frame_count = cnt;
		w.fragment_len = len;
		w.frame_prio = prio;
		w.frame_flags = 8'($urandom);
		w.frame_sdt = 8'($urandom);
		w.frame_af = $urandom;
		tail = (nbytes > 0 && $urandom_range(0, 9) == 0);
		for (i = 0; i < nbytes; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				w.byte_valid = 1'b0;
				w.payload_byte = 8'($urandom);
				w.frame_last = 1'b0;
				send_word(w);
			end
			w.byte_valid = 1'b1;
			w.payload_byte = 8'($urandom);
			w.frame_last = (i == nbytes - 1) && !tail;
			send_word(w);
		end
		if (nbytes == 0 || tail) begin
			w.byte_valid = 1'b0;
			w.payload_byte = 8'($urandom);
			w.frame_last = 1'b1;
			send_word(w);
		end
	endtask

	// long frames are cut short: the verdict only depends on the first word
	function automatic int pick_bytes(int len);
		int r;
		r = $urandom_range(0, 19);
		if (len > 24) return ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(1, 4);
		if (r == 0) return len + $urandom_range(1, 2);
		if (r == 1 && len > 0) return $urandom_range(0, len - 1);
		return len;
	endfunction

	function automatic int pick_len();
		if (max_cur - min_cur <= 16) return $urandom_range(min_cur, max_cur);
		if ($urandom_range(0, 4) != 0) return $urandom_range(min_cur, min_cur + 12);
		return $urandom_range(min_cur, max_cur);
	endfunction

	function automatic void bump_count();
		int r;
		r = $urandom_range(0, 19);
		if (r == 1) cnt_hint = cnt_hint + 16'd2;
		else if (r != 0) cnt_hint = cnt_hint + 16'd1;
	endfunction

	task automatic well_formed();
		int seg, nk, k, tl;
		seg = pick_len();
		if ($urandom_range(0, 9) == 0) cnt_hint = 16'hFFFD;
		else cnt_hint = cnt_hint + 16'd1;
		send_frame(KIND_FIRST, cnt_hint, LEN_W'(seg), tid_cur, pick_bytes(seg));
		nk = $urandom_range(0, 4);
		for (k = 0; k < nk; k++) begin
			bump_count();
			tl = ($urandom_range(0, 19) == 0) ? seg + 1 : seg;
			send_frame(KIND_CONSECUTIVE, cnt_hint, LEN_W'(tl), tid_cur, pick_bytes(tl));
		end
		bump_count();
		tl = ($urandom_range(0, 19) == 0) ? seg + 1 : $urandom_range(0, seg);
		send_frame(KIND_LAST, cnt_hint, LEN_W'(tl), tid_cur, pick_bytes(tl));
	endtask

	task automatic random_phase(int quota);
		int start, r, len;
		start = words_sent;
		while (words_sent - start < quota) begin
			quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 55) begin
				well_formed();
			end else if (r < 67) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(2049, 4095) : $urandom_range(0, 20);
				bump_count();
				send_frame(KIND_SINGLE, cnt_hint, LEN_W'(len), tid_cur, pick_bytes(len));
			end else if (r < 77) begin
				len = $urandom_range(0, 4095);
				bump_count();
				send_frame(3'($urandom_range(KIND_FIRST, KIND_LAST)), cnt_hint, LEN_W'(len),
					tid_cur, pick_bytes(len));
			end else if (r < 87) begin
				len = $urandom_range(0, 4095);
				send_frame(3'($urandom_range(0, 7)), 16'($urandom), LEN_W'(len),
					tid_cur ^ PRIO_W'($urandom_range(1, 2047)), pick_bytes(len));
			end else begin
				len = $urandom_range(0, 4095);
				cnt_hint = 16'($urandom);
				send_frame(3'($urandom_range(0, 7)), cnt_hint, LEN_W'(len), tid_cur,
					$urandom_range(0, 6));
			end
		end
		quiet = 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(logic [CFG_W-1:0] tid_data, int mn, int mx);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_TRANSFER_ID;
		cfg_data <= tid_data;
		@(posedge clk);
		cfg_index <= CFG_MIN_FRAGMENT;
		cfg_data <= CFG_W'(mn);
		@(posedge clk);
		cfg_index <= CFG_MAX_FRAGMENT;
		cfg_data <= CFG_W'(mx);
		@(posedge clk);
		cfg_we <= 1'b0;
		tid_cur = tid_data[PRIO_W-1:0];
		min_cur = mn;
		max_cur = mx;
		settings++;
	endtask

	task automatic directed_run();
		send_frame(KIND_SINGLE, 16'd7, 12'd1, RST_TRANSFER_ID ^ 11'h003, 1);
		send_frame(KIND_SINGLE, 16'hFFFE, 12'd2, tid_cur, 2);
		send_frame(KIND_FIRST, 16'hFFFE, 12'd3, tid_cur, 1);        // repeated counter
		send_frame(KIND_FIRST, 16'hFFFF, 12'd2, tid_cur, 2);
		send_frame(KIND_CONSECUTIVE, 16'd0, 12'd2, tid_cur, 2);     // counter wraps
		send_frame(KIND_LAST, 16'd1, 12'd1, tid_cur, 1);
		send_frame(KIND_CONSECUTIVE, 16'd5, 12'd2, tid_cur, 1);     // out of sequence
		send_frame(KIND_FIRST, 16'd6, 12'd0, tid_cur, 0);           // below min size
		send_frame(KIND_FIRST, 16'd6, 12'd2047, tid_cur, 1);
		send_frame(KIND_LAST, 16'd7, 12'd1, tid_cur, 1);            // top buffer address
		send_frame(KIND_FIRST, 16'd8, 12'd2048, tid_cur, 1);
		send_frame(KIND_CONSECUTIVE, 16'd9, 12'd2048, tid_cur, 1);  // buffer overflow
		send_frame(KIND_CONSECUTIVE, 16'd10, 12'd5, tid_cur, 1);    // wrong segment size
		send_frame(KIND_LAST, 16'd11, 12'd1, tid_cur, 1);
		send_frame(KIND_SINGLE, 16'd12, 12'd4095, tid_cur, 1);
		send_frame(KIND_SINGLE, 16'd13, 12'd0, tid_cur, 0);         // empty packet
		send_frame(KIND_SINGLE, 16'd14, 12'd1, tid_cur, 2);         // surplus byte dropped
		send_frame(KIND_OTHER, 16'd15, 12'd1, tid_cur, 1);
		send_frame(KIND_RESERVED, 16'd16, 12'd1, tid_cur, 1);
		send_frame(KIND_FIRST, 16'd17, 12'd2, tid_cur, 2);
		send_frame(KIND_LAST, 16'd18, 12'd3, tid_cur, 1);           // last longer than segment
	endtask

	initial begin : rx_side
		int hold_left, run_left, accepted, next_hold, holds, pct;
		out_stall = 1'b0;
		hold_left = 0;
		run_left = 0;
		accepted = 0;
		next_hold = 300;
		holds = 0;
		pct = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (in_valid && !in_stall) accepted++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds < 2 && accepted >= next_hold) begin
				hold_left = 400;
				holds++;
				next_hold += 500;
				out_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				if ($urandom_range(0, 15) == 0) begin
					case ($urandom_range(0, 2))
						0: pct = 0;
						1: pct = 25;
						default: pct = 60;
					endcase
				end
				out_stall <= ($urandom_range(0, 99) < pct);
				run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
			end
		end
	end

	initial begin : stimulus
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		words_sent = 0;
		settings = 1;
		tid_cur = RST_TRANSFER_ID;
		min_cur = int'(RST_MIN_FRAGMENT);
		max_cur = int'(RST_MAX_FRAGMENT);
		cnt_hint = 16'($urandom);
		quiet = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_run();
		set_regs(12'h000, 1, 8);
		random_phase(220);
		set_regs(12'hFFF, 4, 4);
		random_phase(200);
		set_regs(CFG_W'($urandom_range(0, 2047)), 1, 2048);
		random_phase(220);
		set_regs(CFG_W'($urandom_range(0, 2047)), 2048, 2048);
		random_phase(120);
		set_regs(CFG_W'($urandom_range(0, 2047)), 3, 20);
		random_phase(240);
		set_regs(CFG_W'(RST_TRANSFER_ID), 2, 16);
		random_phase(200);
		drain();
		repeat (8) @(posedge clk);

		$display("Summary: %0d input words under %0d register settings, %0d result words compared,",
			words_sent, settings, compared);
		$display("         %0d packets reassembled, counter wrap, overflow and drop cases included.",
			packets);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
